[sv/itoa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int MaxWidthDefault = 64;

  localparam logic [2:0] RADIX_DEC = 3'd0;
  localparam logic [2:0] RADIX_BIN = 3'd1;
  localparam logic [2:0] RADIX_OCT = 3'd2;
  localparam logic [2:0] RADIX_HEXL = 3'd3;
  localparam logic [2:0] RADIX_HEXU = 3'd4;

  localparam logic [2:0] REG_RADIX = 3'd0;
  localparam logic [2:0] REG_PREFIX = 3'd1;
  localparam logic [2:0] REG_PAD = 3'd2;
  localparam logic [2:0] REG_NATURAL = 3'd3;
  localparam logic [2:0] REG_FILL = 3'd4;
  localparam logic [2:0] REG_GROUP = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_EMIT
  } state_t;

  // Emission sequence phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREP,
    PH_SIGN,
    PH_PRE0,
    PH_PRE1,
    PH_FILL,
    PH_DIGIT,
    PH_SEP
  } phase_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_start;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic extract_done;
    logic emit_done;
  } status_t;

  function automatic logic [6:0] natural_digits(input logic [2:0] kind,
                                                input logic [1:0] sz);
    logic [6:0] r;
    r = 7'd0;
    unique case (kind)
      RADIX_BIN: begin
        unique case (sz)
          2'd0: r = 7'd8;
          2'd1: r = 7'd16;
          2'd2: r = 7'd32;
          default: r = 7'd64;
        endcase
      end
      RADIX_OCT: begin
        unique case (sz)
          2'd0: r = 7'd3;
          2'd1: r = 7'd6;
          2'd2: r = 7'd11;
          default: r = 7'd22;
        endcase
      end
      RADIX_HEXL, RADIX_HEXU: begin
        unique case (sz)
          2'd0: r = 7'd2;
          2'd1: r = 7'd4;
          2'd2: r = 7'd8;
          default: r = 7'd16;
        endcase
      end
      default: begin
        unique case (sz)
          2'd0: r = 7'd3;
          2'd1: r = 7'd5;
          2'd2: r = 7'd10;
          default: r = 7'd20;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return 8'h30 + {4'd0, d};
    end
    return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
  endfunction

endpackage
`default_nettype wire

[sv/itoa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module itoa_ram #(
  parameter int Width = 4,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/itoa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: extraction pass, then emission pass.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire itoa_pkg::status_t status,
  output itoa_pkg::ctrl_t        ctrl,
  output logic                   busy
);
  import itoa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_EXTRACT;
      ST_EXTRACT: if (status.extract_done) state_next = ST_EMIT;
      ST_EMIT: if (status.emit_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: ctrl.load = start;
      ST_EXTRACT: begin
        ctrl.step = 1'b1;
        ctrl.emit_start = status.extract_done;
      end
      ST_EMIT: ctrl.emit = 1'b1;
      default: ctrl = '0;
    endcase
  end
endmodule
`default_nettype wire

[sv/itoa_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_datapath
// Digit extraction into the digit store, and character emission in pairs.
// ----------------------------------------------------------------------------
module itoa_datapath #(
  parameter int MaxWidth = itoa_pkg::MaxWidthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire itoa_pkg::ctrl_t   ctrl,
  output itoa_pkg::status_t      status,
  input  wire logic [63:0]       number,
  input  wire logic [1:0]        size_code,
  input  wire logic              is_signed,
  input  wire logic [2:0]        radix_kind,
  input  wire logic              prefix_enable,
  input  wire logic [6:0]        pad_width,
  input  wire logic              natural_width,
  input  wire logic [7:0]        fill_char,
  input  wire logic              group_enable,
  output logic [7:0]             first_char,
  output logic [7:0]             second_char,
  output logic                   second_valid,
  output logic                   last,
  output logic                   strobe
);
  import itoa_pkg::*;

  localparam logic [6:0] MaxW = 7'(MaxWidth);
  // Ten's reciprocal scaled by 2^23; exact for every dividend below 2^22.
  localparam logic [19:0] RecipTen = 20'd838861;

  logic [63:0] mag, quot;
  logic [2:0]  kind;
  logic        sgn, neg;
  logic [1:0]  sz;
  logic [6:0]  digit_count;
  logic [1:0]  cnt_mod3;
  logic [1:0]  chunk;
  logic [3:0]  rem;

  // Digit store.
  logic        we;
  logic [5:0]  waddr, raddr;
  logic [3:0]  wdata, rdata;

  itoa_ram #(.Width(4), .Depth(64)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // Decimal digits come from a long division by ten over four 16-bit chunks,
  // most significant chunk first, one chunk a cycle.
  logic [19:0] div_in, div_rem;
  logic [39:0] div_prod;
  logic [15:0] div_q;
  always_comb begin
    div_in = {rem, mag[63:48]};
    div_prod = 40'(div_in) * 40'(RecipTen);
    div_q = div_prod[38:23];
    div_rem = div_in - 20'(div_q) * 20'd10;
  end

  logic [3:0] low_digit;
  always_comb begin
    unique case (kind)
      RADIX_BIN: low_digit = {3'd0, mag[0]};
      RADIX_OCT: low_digit = {1'b0, mag[2:0]};
      default: low_digit = mag[3:0];
    endcase
  end

  logic [63:0] mag_shift;
  always_comb begin
    unique case (kind)
      RADIX_BIN: mag_shift = mag >> 1;
      RADIX_OCT: mag_shift = mag >> 3;
      default: mag_shift = mag >> 4;
    endcase
  end

  logic [63:0] in_mask, in_val, in_ext;
  logic        load_neg;
  always_comb begin
    unique case (size_code)
      2'd0: in_mask = 64'hFF;
      2'd1: in_mask = 64'hFFFF;
      2'd2: in_mask = 64'hFFFF_FFFF;
      default: in_mask = '1;
    endcase
    in_val = number & in_mask;
    in_ext = in_val;
    if (is_signed && (((in_mask >> 1) + 64'd1) & in_val) != 64'd0) begin
      in_ext = in_val | ~in_mask;
    end
    load_neg = is_signed && in_ext[63] &&
               (radix_kind == RADIX_DEC || radix_kind > RADIX_HEXU);
  end

  // Value left once the current digit is taken.
  logic [63:0] mag_after;
  logic        digit_ready;
  always_comb begin
    if (kind == RADIX_DEC) begin
      digit_ready = (chunk == 2'd3);
      wdata = div_rem[3:0];
      mag_after = {quot[47:0], div_q};
    end else begin
      digit_ready = 1'b1;
      wdata = low_digit;
      mag_after = mag_shift;
    end
  end

  assign we = ctrl.step && digit_ready;
  assign waddr = digit_count[5:0];
  assign status.extract_done = we && (mag_after == 64'd0 || digit_count == 7'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      cnt_mod3 <= '0;
      chunk <= '0;
    end else if (ctrl.load) begin
      digit_count <= '0;
      cnt_mod3 <= '0;
      chunk <= '0;
    end else if (ctrl.step) begin
      chunk <= (kind == RADIX_DEC) ? chunk + 2'd1 : 2'd0;
      if (digit_ready) begin
        digit_count <= digit_count + 7'd1;
        cnt_mod3 <= (cnt_mod3 == 2'd2) ? 2'd0 : cnt_mod3 + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      kind <= (radix_kind > RADIX_HEXU) ? RADIX_DEC : radix_kind;
      sgn <= is_signed;
      sz <= size_code;
      neg <= load_neg;
      mag <= load_neg ? 64'd0 - in_ext : in_ext;
      rem <= '0;
      quot <= '0;
    end else if (ctrl.step) begin
      if (kind == RADIX_DEC) begin
        if (chunk == 2'd3) begin
          mag <= mag_after;
          rem <= '0;
          quot <= '0;
        end else begin
          mag <= {mag[47:0], 16'd0};
          rem <= div_rem[3:0];
          quot <= {quot[47:0], div_q};
        end
      end else begin
        mag <= mag_shift;
      end
    end
  end

  // Emission.
  logic [6:0] width_sel, fill_total, fill_cnt, g, after, after_next;
  logic [1:0] grp, grp_next;
  logic       sep_en, sep_here, last_char;
  phase_t     ph, ph_next;
  logic [7:0] ch, half;
  logic       ch_valid, have_half;

  always_comb begin
    if (natural_width) width_sel = natural_digits(kind, sz);
    else width_sel = (pad_width > MaxW) ? MaxW : pad_width;
    fill_total = (width_sel > digit_count) ? width_sel - digit_count : 7'd0;
    unique case (kind)
      RADIX_BIN: g = 7'd8;
      RADIX_OCT, RADIX_DEC: g = 7'd3;
      default: g = 7'd2;
    endcase
    sep_en = group_enable && !sgn && digit_count > g;
    // The count of digits still to follow is a multiple of the group size;
    // grp tracks that count modulo three.
    unique case (kind)
      RADIX_BIN: sep_here = (after[2:0] == 3'd0);
      RADIX_HEXL, RADIX_HEXU: sep_here = (after[0] == 1'b0);
      default: sep_here = (grp == 2'd0);
    endcase
  end

  always_comb begin
    ph_next = ph;
    after_next = after;
    grp_next = grp;
    ch = 8'd0;
    ch_valid = 1'b0;
    last_char = 1'b0;
    if (ctrl.emit) begin
      unique case (ph)
        PH_PREP: begin
          // This phase lets the first digit read settle in the store.
          after_next = digit_count - 7'd1;
          grp_next = (cnt_mod3 == 2'd0) ? 2'd2 : cnt_mod3 - 2'd1;
          if (sgn) ph_next = neg ? PH_SIGN : PH_DIGIT;
          else if (prefix_enable) ph_next = PH_PRE0;
          else if (fill_total != 7'd0) ph_next = PH_FILL;
          else ph_next = PH_DIGIT;
        end
        PH_SIGN: begin
          ch = 8'h2D;
          ch_valid = 1'b1;
          ph_next = PH_DIGIT;
        end
        PH_PRE0: begin
          ch = 8'h30;
          ch_valid = 1'b1;
          ph_next = PH_PRE1;
        end
        PH_PRE1: begin
          ch_valid = 1'b1;
          unique case (kind)
            RADIX_BIN: ch = 8'h62;
            RADIX_OCT: ch = 8'h6F;
            RADIX_HEXL, RADIX_HEXU: ch = 8'h78;
            default: ch = 8'h64;
          endcase
          ph_next = (fill_total != 7'd0) ? PH_FILL : PH_DIGIT;
        end
        PH_FILL: begin
          ch = fill_char;
          ch_valid = 1'b1;
          ph_next = (fill_cnt + 7'd1 >= fill_total) ? PH_DIGIT : PH_FILL;
        end
        PH_DIGIT: begin
          ch = digit_char(rdata, kind == RADIX_HEXU);
          ch_valid = 1'b1;
          if (after == 7'd0) begin
            last_char = 1'b1;
            ph_next = PH_IDLE;
          end else begin
            after_next = after - 7'd1;
            grp_next = (grp == 2'd0) ? 2'd2 : grp - 2'd1;
            ph_next = (sep_en && sep_here) ? PH_SEP : PH_DIGIT;
          end
        end
        PH_SEP: begin
          ch = (kind == RADIX_DEC) ? 8'h2E : 8'h5F;
          ch_valid = 1'b1;
          ph_next = PH_DIGIT;
        end
        default: ph_next = PH_IDLE;
      endcase
    end
  end

  assign status.emit_done = last_char;
  assign raddr = after_next[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
      after <= '0;
      grp <= '0;
      fill_cnt <= '0;
      have_half <= 1'b0;
      strobe <= 1'b0;
      last <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last <= 1'b0;
      after <= after_next;
      grp <= grp_next;
      if (ctrl.emit_start) begin
        ph <= PH_PREP;
        fill_cnt <= '0;
        have_half <= 1'b0;
      end else begin
        ph <= ph_next;
        if (ctrl.emit && ph == PH_FILL) fill_cnt <= fill_cnt + 7'd1;
        if (ch_valid) begin
          if (have_half || last_char) begin
            strobe <= 1'b1;
            last <= last_char;
            have_half <= 1'b0;
          end else begin
            have_half <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ch_valid) begin
      if (have_half) begin
        first_char <= half;
        second_char <= ch;
        second_valid <= 1'b1;
      end else begin
        half <= ch;
        first_char <= ch;
        second_char <= 8'd0;
        second_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[sv/integer_to_ascii_formatter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats an 8/16/32/64-bit integer as ASCII text, up to two characters a result.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// command   start & !busy         number, size_code, is_signed
// result    strobe (no stall)     first_char, second_char, second_valid, last
// config    cfg_we                cfg_index, cfg_data
//
// Decimal extraction divides by ten over four 16-bit chunks for each digit;
// other radixes extract one digit a cycle. Emission first primes the digit
// store read, then emits one character per cycle. busy falls as the final
// result is strobed. Reset is synchronous; the digit store needs no clearing
// since every digit read was written for the same number.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
  parameter int MAX_WIDTH = itoa_pkg::MaxWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] number,
  input  wire logic [1:0]  size_code,
  input  wire logic        is_signed,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             strobe,
  output logic [7:0]       first_char,
  output logic [7:0]       second_char,
  output logic             second_valid,
  output logic             last
);
  import itoa_pkg::*;

  logic [2:0] radix_kind;
  logic       prefix_enable, natural_width, group_enable;
  logic [6:0] pad_width;
  logic [7:0] fill_char;
  ctrl_t      ctrl;
  status_t    status;
  logic       ctrl_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_kind <= RADIX_DEC;
      prefix_enable <= 1'b0;
      pad_width <= '0;
      natural_width <= 1'b0;
      fill_char <= 8'h30;
      group_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX: radix_kind <= cfg_data[2:0];
        REG_PREFIX: prefix_enable <= cfg_data[0];
        REG_PAD: pad_width <= cfg_data[6:0];
        REG_NATURAL: natural_width <= cfg_data[0];
        REG_FILL: fill_char <= cfg_data;
        REG_GROUP: group_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ctrl_start = start;

  itoa_ctrl u_ctrl (
    .clk, .rst, .start(ctrl_start), .status, .ctrl, .busy
  );

  itoa_datapath #(.MaxWidth(MAX_WIDTH)) u_dp (
    .clk, .rst, .ctrl, .status, .number, .size_code, .is_signed,
    .radix_kind, .prefix_enable, .pad_width, .natural_width, .fill_char,
    .group_enable, .first_char, .second_char, .second_valid, .last, .strobe
  );

  a_last_strobe: assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without strobe");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe)
    else $error("result while idle");
  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load, ctrl.step, ctrl.emit}))
    else $error("overlapping commands");
endmodule
`default_nettype wire
